// ===== design/vsfd_pkg.sv =====
// package for the sign-folded varint decoder
// constants and decode kind codes shared by the top level and the fold unit
`timescale 1ns / 1ps

package vsfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned GROUP_W = 7;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 4;
  localparam int unsigned KIND_W  = 2;

  // groups at this index and above add nothing
  localparam logic [3:0] GROUP_LIMIT = 4'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

  typedef enum logic [KIND_W-1:0] {
    KIND_S32 = 2'd0,
    KIND_S64 = 2'd1,
    KIND_U64 = 2'd2,
    KIND_U64_ALT = 2'd3
  } kind_t;

endpackage

// ===== design/vsfd_fold.sv =====
// output mapping of the sign-folded varint decoder
// depends on vsfd_pkg for widths and decode kind codes
`timescale 1ns / 1ps

module vsfd_fold (
  input  logic [vsfd_pkg::VALUE_W-1:0] acc,
  input  logic [vsfd_pkg::KIND_W-1:0]  kind,
  output logic [vsfd_pkg::VALUE_W-1:0] value
);
  import vsfd_pkg::*;

  logic [VALUE_W-1:0] half64;
  logic [VALUE_W-1:0] fold64;
  logic [31:0]        half32;
  logic [31:0]        fold32;

  always_comb begin
    // odd values: v-1 halved equals v halved, then negated
    half64 = acc >> 1;
    fold64 = acc[0] ? (VALUE_W'(0) - half64) : half64;
    half32 = acc[31:0] >> 1;
    fold32 = acc[0] ? (32'd0 - half32) : half32;
  end

  always_comb begin
    case (kind)
      KIND_S32: value = {{(VALUE_W-32){fold32[31]}}, fold32};
      KIND_S64: value = fold64;
      default:  value = acc;
    endcase
  end

endmodule

// ===== design/varint_sign_folded_decoder_top.sv =====
// top level of the sign-folded varint decoder
// depends on vsfd_pkg and vsfd_fold
`timescale 1ns / 1ps

// Decodes LEB128-style varints, one byte per item, and delivers one result
// item per value when a byte with bit 7 clear arrives. Each byte adds its low
// seven bits into a 64-bit accumulator at weight 128^k; groups past bit 63 are
// dropped. func on the final byte picks the mapping: 0 signed 32-bit, 1 signed
// 64-bit, 2 or 3 unsigned 64-bit. Signed modes map even v to v/2 and odd v to
// -(v-1)/2, sign-extended to 64 bits. byte_count saturates at 15. Throughput
// is one byte per cycle while in_ready is high: the accumulator update is a
// single shift-or, the finished value passes a stage register, then the fold
// and the result register. Ready drops only when both stages hold items the
// consumer has not taken.
module varint_sign_folded_decoder_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [vsfd_pkg::BYTE_W-1:0]   data_byte,
  input  logic [vsfd_pkg::KIND_W-1:0]   func,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vsfd_pkg::VALUE_W-1:0]  value,
  output logic [vsfd_pkg::COUNT_W-1:0]  byte_count
);
  import vsfd_pkg::*;

  // decode state
  logic [VALUE_W-1:0] accumulator;
  logic [3:0]         group_index;
  logic [COUNT_W-1:0] bytes_seen;

  // finished-value stage
  logic               mid_valid;
  logic [VALUE_W-1:0] mid_acc;
  logic [KIND_W-1:0]  mid_kind;
  logic [COUNT_W-1:0] mid_count;

  logic               in_fire;
  logic               final_byte;
  logic               out_free;
  logic               mid_move;
  logic [6:0]         shift_amt;
  logic [VALUE_W-1:0] group_bits;
  logic [VALUE_W-1:0] acc_next;
  logic [COUNT_W-1:0] count_next;
  logic [VALUE_W-1:0] fold_value;

  // pipeline flow control
  assign out_free   = !out_valid || out_ready;
  assign mid_move   = mid_valid && out_free;
  assign in_ready   = !mid_valid || out_free;
  assign in_fire    = in_valid && in_ready;
  assign final_byte = !data_byte[BYTE_W-1];

  // place the new group; groups never overlap earlier ones, so an or is an add
  always_comb begin
    shift_amt  = 7'(group_index) * 7'(GROUP_W);
    group_bits = VALUE_W'(data_byte[GROUP_W-1:0]) << shift_amt;
    if (group_index >= GROUP_LIMIT) begin
      acc_next = accumulator;
    end else begin
      acc_next = accumulator | group_bits;
    end
    count_next = (bytes_seen == COUNT_MAX) ? COUNT_MAX : bytes_seen + COUNT_W'(1);
  end

  // accumulator, group and byte counters
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      group_index <= '0;
      bytes_seen  <= '0;
    end else if (in_fire) begin
      if (final_byte) begin
        accumulator <= '0;
        group_index <= '0;
        bytes_seen  <= '0;
      end else begin
        accumulator <= acc_next;
        if (group_index < GROUP_LIMIT) begin
          group_index <= group_index + 4'd1;
        end
        bytes_seen <= count_next;
      end
    end
  end

  // finished value waits here for the fold
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_fire && final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && final_byte) begin
      mid_acc   <= acc_next;
      mid_kind  <= func;
      mid_count <= count_next;
    end
  end

  vsfd_fold u_fold (
    .acc   (mid_acc),
    .kind  (mid_kind),
    .value (fold_value)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_move) begin
      value      <= fold_value;
      byte_count <= mid_count;
    end
  end

endmodule

// ===== bench/varint_sign_folded_decoder_top_test.sv =====
// self-checking bench for the sign-folded varint decoder top level
// depends on vsfd_pkg and the design files under design/
`timescale 1ns / 1ps

module varint_sign_folded_decoder_top_test;
  import vsfd_pkg::*;

  localparam int unsigned BYTE_TARGET = 1550;
  localparam int unsigned CYCLE_LIMIT = 600000;
  // wait after the drain for the stage and result registers to show a stray result
  localparam int unsigned DRAIN_CYCLES = 8;

  // tracks the running value and holds decoded results still to arrive
  class varint_scoreboard;
    logic [VALUE_W-1:0] acc;
    logic [3:0]         grp;
    logic [COUNT_W-1:0] seen;
    logic [VALUE_W-1:0] value_q[$];
    logic [COUNT_W-1:0] count_q[$];
    int errors;
    int results;
    int longest;
    int kind_hits[4];

    function new();
      acc = '0;
      grp = '0;
      seen = '0;
      errors = 0;
      results = 0;
      longest = 0;
      foreach (kind_hits[i]) kind_hits[i] = 0;
    endfunction

    // odd v maps to -(v-1)/2, even v to v/2
    function logic [VALUE_W-1:0] fold64(logic [VALUE_W-1:0] v);
      if (v[0]) return '0 - ((v - 64'd1) >> 1);
      return v >> 1;
    endfunction

    function logic [VALUE_W-1:0] fold32(logic [VALUE_W-1:0] v);
      logic [31:0] lo;
      logic [31:0] r;
      lo = v[31:0];
      if (lo[0]) r = 32'd0 - ((lo - 32'd1) >> 1);
      else r = lo >> 1;
      return {{32{r[31]}}, r};
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic [KIND_W-1:0] f);
      logic [VALUE_W-1:0] group;
      logic [VALUE_W-1:0] sum;
      logic [COUNT_W-1:0] cnt;
      kind_t kind;
      group = {57'd0, b[6:0]};
      // groups past the limit add nothing, the tenth keeps only bit 63
      sum = (grp < GROUP_LIMIT) ? acc + (group << (int'(grp) * 7)) : acc;
      if (b[7]) begin
        acc = sum;
        if (grp < GROUP_LIMIT) grp = grp + 4'd1;
        if (seen < COUNT_MAX) seen = seen + 4'd1;
        return;
      end
      cnt = (seen == COUNT_MAX) ? COUNT_MAX : seen + 4'd1;
      if (int'(seen) + 1 > longest) longest = int'(seen) + 1;
      kind = kind_t'(f);
      kind_hits[f]++;
      case (kind)
        KIND_S32: value_q.push_back(fold32(sum));
        KIND_S64: value_q.push_back(fold64(sum));
        default:  value_q.push_back(sum);
      endcase
      count_q.push_back(cnt);
      acc = '0;
      grp = '0;
      seen = '0;
    endfunction

    function void check_result(logic [VALUE_W-1:0] v, logic [COUNT_W-1:0] c);
      logic [VALUE_W-1:0] ev;
      logic [COUNT_W-1:0] ec;
      if (value_q.size() == 0) begin
        $display("%0t: unexpected result value %h byte_count %0d", $time, v, c);
        errors++;
        return;
      end
      ev = value_q.pop_front();
      ec = count_q.pop_front();
      results++;
      if (v !== ev) begin
        $display("%0t: value expected %h actual %h", $time, ev, v);
        errors++;
      end
      if (c !== ec) begin
        $display("%0t: byte_count expected %0d actual %0d", $time, ec, c);
        errors++;
      end
    endfunction

    function int pending();
      return value_q.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [BYTE_W-1:0]  data_byte;
  logic [KIND_W-1:0]  func;
  logic               out_valid;
  logic               out_ready;
  logic [VALUE_W-1:0] value;
  logic [COUNT_W-1:0] byte_count;

  varint_scoreboard board;
  int unsigned bytes_sent;
  int unsigned cycles;
  // while set, neither side idles
  bit calm;

  varint_sign_folded_decoder_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .func       (func),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .byte_count (byte_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one byte and hold it until the block takes it
  task send_byte(input logic [BYTE_W-1:0] b, input logic [KIND_W-1:0] f);
    int gap;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    func <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_byte(b, f);
    bytes_sent++;
  endtask

  // one value of len bytes; continuation bit on all but the last
  task send_value(input int len, input logic [KIND_W-1:0] f);
    logic [6:0] grp_bits;
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10) grp_bits = 7'h7f;
      else if (r < 15) grp_bits = 7'h00;
      else grp_bits = 7'($urandom_range(0, 127));
      // only the final byte's func matters, the rest is noise
      send_byte({(i < len - 1) ? 1'b1 : 1'b0, grp_bits},
                (i < len - 1) ? 2'($urandom_range(0, 3)) : f);
    end
  endtask

  // consumer side: alternate ready and stall stretches of random length
  initial begin
    int hold;
    bit rdy;
    hold = 0;
    rdy = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        rdy = !rdy;
        hold = rdy ? $urandom_range(0, 12) : pick_gap();
        out_ready <= rdy;
      end
    end
  end

  // output monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      cycles++;
      if (out_valid && out_ready) board.check_result(value, byte_count);
      if (cycles > CYCLE_LIMIT) begin
        $display("%0t: timeout, %0d results still expected", $time, board.pending());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int r;
    board = new();
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = '0;
    func = KIND_S32;
    bytes_sent = 0;
    cycles = 0;
    calm = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // zero in every decode kind, including the unused code
    send_byte(8'h00, KIND_S32);
    send_byte(8'h00, KIND_S64);
    send_byte(8'h00, KIND_U64);
    send_byte(8'h00, KIND_U64_ALT);
    // one decodes to zero in signed mode
    send_byte(8'h01, KIND_S64);
    // overlong: fifteen continuation bytes, count saturates, high groups drop
    for (int i = 0; i < 15; i++) send_byte(8'hff, KIND_U64);
    send_byte(8'h7f, KIND_S64);

    // random values; mostly short, five bytes crosses the 32-bit boundary
    while (bytes_sent < BYTE_TARGET) begin
      calm = ((bytes_sent / 150) % 4) == 3;
      r = $urandom_range(0, 99);
      if (r < 55) len = $urandom_range(1, 3);
      else if (r < 85) len = $urandom_range(4, 6);
      else if (r < 95) len = $urandom_range(7, 10);
      else len = $urandom_range(11, 20);
      send_value(len, 2'($urandom_range(0, 3)));
    end
    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b0;

    // drain, then give the pipeline time to show any stray result
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // a stray result may still be held by a stalled consumer
    if (out_valid) begin
      $display("%0t: stray result still held, value %h byte_count %0d",
               $time, value, byte_count);
      board.errors++;
    end

    $display("sent %0d bytes forming %0d values, longest value %0d bytes",
             bytes_sent, board.results, board.longest);
    $display("final kinds s32/s64/u64/alt: %0d/%0d/%0d/%0d",
             board.kind_hits[0], board.kind_hits[1], board.kind_hits[2],
             board.kind_hits[3]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
